// ===== rtl/cfdl_pkg.sv =====
// Shared widths, datapath types and microcode word format for the cubic
// fractional delay line. No dependencies; every other file imports it.
package cfdl_pkg;

  // Item field widths
  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned FRACTION_BITS  = 16;
  localparam int unsigned WHOLE_BITS     = 12;
  localparam int unsigned RING_DEPTH_DEF = 4096;

  // Stereo: lane 0 is left, lane 1 is right
  localparam int unsigned LANES = 2;

  // Horner accumulator holds at most 24 times the sample range
  localparam int unsigned ACC_BITS  = SAMPLE_BITS + 6;
  localparam int unsigned PROD_BITS = ACC_BITS + FRACTION_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;

  // Microprogram
  localparam int unsigned STEP_BITS = 4;

  typedef enum logic [1:0] {
    TAP_NEWER,
    TAP_BASE,
    TAP_OLDER,
    TAP_OLDEST
  } tap_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_COEF,
    OP_MUL,
    OP_ADD,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    ADD_D2,
    ADD_D1,
    ADD_Y0
  } add_e;

  typedef struct packed {
    logic                 in_wait;   // offer ready, hold until an item arrives
    logic                 out_wait;  // hold while the output register is busy
    logic                 rd_en;
    tap_e                 rd_tap;
    logic                 cap_en;
    tap_e                 cap_tap;
    op_e                  op;
    add_e                 add_src;
    logic [STEP_BITS-1:0] next;
  } ucode_t;

endpackage

// ===== rtl/cfdl_in_if.sv =====
// Input channel of the cubic fractional delay line: valid/ready handshake
// carrying one stereo sample and the delay. Depends on cfdl_pkg.
interface cfdl_in_if import cfdl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  sample_t                  in_left;
  sample_t                  in_right;
  logic [WHOLE_BITS-1:0]    delay_whole;
  logic [FRACTION_BITS-1:0] delay_fraction;

  modport source (
    output valid, in_left, in_right, delay_whole, delay_fraction,
    input  ready
  );

  modport sink (
    input  valid, in_left, in_right, delay_whole, delay_fraction,
    output ready
  );
endinterface

// ===== rtl/cfdl_out_if.sv =====
// Output channel of the cubic fractional delay line: valid/ready handshake
// carrying one interpolated stereo sample. Depends on cfdl_pkg.
interface cfdl_out_if import cfdl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;

  modport source (
    output valid, out_left, out_right,
    input  ready
  );

  modport sink (
    input  valid, out_left, out_right,
    output ready
  );
endinterface

// ===== rtl/cfdl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on cfdl_pkg for default sizes only.
module cfdl_ram import cfdl_pkg::*; #(
  parameter int unsigned WIDTH = 2 * SAMPLE_BITS,
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cubic_fractional_delay_line.sv =====
// Stereo delay line with 4-point Catmull-Rom cubic interpolation.
// One item at a time: the microprogram accepts no new item until the last
// result is committed, after four serial reads on the ring's one read port,
// a coefficient step, then three Horner steps, each a multiply and an add.
// Reset: pointer to zero, ring reads as zero until each entry is first
// written (tracked by pointer and wrap flag, no clearing pass), no result held.
module cubic_fractional_delay_line import cfdl_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfdl_in_if.sink    in_i,
  cfdl_out_if.source out_o
);

  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned AW1 = AW + 1;
  localparam int unsigned CW  = ((AW > WHOLE_BITS) ? AW : WHOLE_BITS) + 1;

  localparam logic [AW-1:0] WP_LAST   = AW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] WHOLE_MAX = AW'(RING_DEPTH - 4);
  localparam prod_t         HALF      = prod_t'(1) <<< (FRACTION_BITS - 1);
  localparam acc_t          SAT_MAX   = acc_t'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
  localparam acc_t          SAT_MIN   = ~SAT_MAX;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t w;
    w          = '0;
    w.rd_tap   = TAP_NEWER;
    w.cap_tap  = TAP_NEWER;
    w.op       = OP_NOP;
    w.add_src  = ADD_D2;
    w.next     = step + STEP_BITS'(1);
    unique case (step)
      4'd0:  w.in_wait = 1'b1;
      4'd1:  begin
        w.rd_en  = 1'b1;
        w.rd_tap = TAP_NEWER;
      end
      4'd2:  begin
        w.rd_en   = 1'b1;
        w.rd_tap  = TAP_BASE;
        w.cap_en  = 1'b1;
        w.cap_tap = TAP_NEWER;
      end
      4'd3:  begin
        w.rd_en   = 1'b1;
        w.rd_tap  = TAP_OLDER;
        w.cap_en  = 1'b1;
        w.cap_tap = TAP_BASE;
      end
      4'd4:  begin
        w.rd_en   = 1'b1;
        w.rd_tap  = TAP_OLDEST;
        w.cap_en  = 1'b1;
        w.cap_tap = TAP_OLDER;
      end
      4'd5:  w.op = OP_COEF;
      4'd6:  w.op = OP_MUL;
      4'd7:  begin
        w.op      = OP_ADD;
        w.add_src = ADD_D2;
      end
      4'd8:  w.op = OP_MUL;
      4'd9:  begin
        w.op      = OP_ADD;
        w.add_src = ADD_D1;
      end
      4'd10: w.op = OP_MUL;
      4'd11: begin
        w.op      = OP_ADD;
        w.add_src = ADD_Y0;
      end
      4'd12: begin
        w.op       = OP_OUT;
        w.out_wait = 1'b1;
        w.next     = '0;
      end
      default: w.next = '0;
    endcase
    return w;
  endfunction

  logic [STEP_BITS-1:0] pc_q, pc_d;
  ucode_t               uc;
  logic                 in_acc;
  logic                 out_busy;
  logic                 out_commit;
  logic                 hold;

  logic [AW-1:0]        wp_q;
  logic                 full_q;
  logic [AW-1:0]        base_q, base_d;
  logic [FRACTION_BITS-1:0] f_q;
  logic                 clamp;
  logic [AW-1:0]        whole_eff;
  logic [AW1-1:0]       base_diff;

  logic [AW-1:0]        rd_addr;
  logic [AW1-1:0]       base_ext;
  logic                 rd_ok, rd_ok_q;
  logic [2*SAMPLE_BITS-1:0] ram_rdata;

  sample_t ym1_q [LANES];
  sample_t y0_q  [LANES];
  sample_t y1_q  [LANES];
  acc_t    d1_q  [LANES];
  acc_t    d2_q  [LANES];
  acc_t    a_q   [LANES];
  prod_t   p_q   [LANES];

  sample_t samp     [LANES];
  acc_t    coef_d1  [LANES];
  acc_t    coef_d2  [LANES];
  acc_t    coef_d3  [LANES];
  prod_t   prod     [LANES];
  acc_t    rnd      [LANES];
  acc_t    add_val  [LANES];
  acc_t    sum_a    [LANES];
  sample_t sat_res  [LANES];

  logic    out_valid_q;
  sample_t out_left_q;
  sample_t out_right_q;

  // Sequencer control
  assign uc         = ucode_rom(pc_q);
  assign in_i.ready = uc.in_wait;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_busy   = out_valid_q && !out_o.ready;
  assign hold       = (uc.in_wait && !in_acc) || (uc.out_wait && out_busy);
  assign pc_d       = hold ? pc_q : uc.next;
  assign out_commit = (uc.op == OP_OUT) && !out_busy;

  // Clamp the delay and find the base index behind the write pointer
  always_comb begin
    clamp     = CW'(in_i.delay_whole) >= CW'(RING_DEPTH - 4);
    whole_eff = clamp ? WHOLE_MAX : AW'(in_i.delay_whole);
    base_diff = {1'b0, wp_q} - {1'b0, whole_eff};
    base_d    = base_diff[AW] ? AW'(base_diff + AW1'(RING_DEPTH)) : AW'(base_diff);
  end

  // Neighbor address for the read tap, modulo the ring depth
  always_comb begin
    base_ext = {1'b0, base_q};
    case (uc.rd_tap)
      TAP_NEWER:  rd_addr = (base_q == WP_LAST) ? '0 : base_q + AW'(1);
      TAP_BASE:   rd_addr = base_q;
      TAP_OLDER:  rd_addr = (base_q == '0) ? WP_LAST : base_q - AW'(1);
      TAP_OLDEST: rd_addr = (base_q >= AW'(2)) ? base_q - AW'(2)
                                               : AW'(base_ext + AW1'(RING_DEPTH - 2));
      default:    rd_addr = base_q;
    endcase
    // entries never written read as zero
    rd_ok = full_q || (rd_addr < wp_q);
  end

  cfdl_ram #(
    .WIDTH(2 * SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(wp_q),
    .wdata_i({in_i.in_right, in_i.in_left}),
    .re_i   (uc.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Lane arithmetic: coefficients, multiply, round and add, saturate
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      samp[l]    = rd_ok_q ? sample_t'(ram_rdata[l*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
      coef_d1[l] = acc_t'(y1_q[l]) - acc_t'(ym1_q[l]);
      coef_d2[l] = (acc_t'(ym1_q[l]) <<< 1) - ((acc_t'(y0_q[l]) <<< 2) + acc_t'(y0_q[l]))
                   + (acc_t'(y1_q[l]) <<< 2) - acc_t'(samp[l]);
      coef_d3[l] = (acc_t'(samp[l]) - acc_t'(ym1_q[l]))
                   + ((acc_t'(y0_q[l]) - acc_t'(y1_q[l])) <<< 1)
                   + (acc_t'(y0_q[l]) - acc_t'(y1_q[l]));
      prod[l]    = prod_t'(a_q[l]) * prod_t'($signed({1'b0, f_q}));
      rnd[l]     = acc_t'((p_q[l] + HALF) >>> FRACTION_BITS);
      case (uc.add_src)
        ADD_D2:  add_val[l] = d2_q[l];
        ADD_D1:  add_val[l] = d1_q[l];
        ADD_Y0:  add_val[l] = acc_t'(y0_q[l]) <<< 1;
        default: add_val[l] = d2_q[l];
      endcase
      sum_a[l] = rnd[l] + add_val[l];
      // halve with rounding, then clip to the sample range
      if (((a_q[l] + acc_t'(1)) >>> 1) > SAT_MAX) begin
        sat_res[l] = sample_t'(SAT_MAX);
      end else if (((a_q[l] + acc_t'(1)) >>> 1) < SAT_MIN) begin
        sat_res[l] = sample_t'(SAT_MIN);
      end else begin
        sat_res[l] = sample_t'((a_q[l] + acc_t'(1)) >>> 1);
      end
    end
  end

  // Step counter, write pointer and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (in_acc) begin
        wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
        if (wp_q == WP_LAST) begin
          full_q <= 1'b1;
        end
      end
      if (out_commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q <= base_d;
      f_q    <= clamp ? '0 : in_i.delay_fraction;
    end
    if (uc.rd_en) begin
      rd_ok_q <= rd_ok;
    end
    for (int l = 0; l < LANES; l++) begin
      if (uc.cap_en) begin
        case (uc.cap_tap)
          TAP_NEWER: ym1_q[l] <= samp[l];
          TAP_BASE:  y0_q[l]  <= samp[l];
          TAP_OLDER: y1_q[l]  <= samp[l];
          default:   ;
        endcase
      end
      case (uc.op)
        OP_COEF: begin
          d1_q[l] <= coef_d1[l];
          d2_q[l] <= coef_d2[l];
          a_q[l]  <= coef_d3[l];
        end
        OP_MUL:  p_q[l] <= prod[l];
        OP_ADD:  a_q[l] <= sum_a[l];
        default: ;
      endcase
    end
    if (out_commit) begin
      out_left_q  <= sat_res[0];
      out_right_q <= sat_res[1];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;

`ifndef ASSERT_OFF
  // an accepted item starts the program, so no second item until it ends
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input ready right after an accepted item");

  // a result appears only from the output step
  a_result_from_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(uc.op == OP_OUT))
    else $error("result raised outside the output step");

  // one ring write per item, pointer wraps at the depth
  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> wp_q == (($past(wp_q) == WP_LAST) ? '0 : $past(wp_q) + AW'(1)))
    else $error("write pointer did not advance by one");

  a_wp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(wp_q))
    else $error("write pointer moved without an item");

  // once the ring has wrapped every entry stays written
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("wrap flag dropped");
`endif

endmodule
